>>> src/bfaq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfaq_pkg
// Shared constants, codes and types of the bloom filter add/query block.
// ----------------------------------------------------------------------------
package bfaq_pkg;

	// Store geometry
	localparam int STORE_BITS_LOG2 = 20;
	localparam int KEY_BYTES = 8;
	localparam int STORE_WORDS = 1 << (STORE_BITS_LOG2 - 6);
	localparam int ADDR_W = (STORE_BITS_LOG2 > 6) ? STORE_BITS_LOG2 - 6 : 1;
	localparam int POS_W = STORE_BITS_LOG2;
	localparam int CNT_W = STORE_BITS_LOG2 + 1;

	// Murmur constants
	localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
	localparam int MUR_R = 47;

	// Item commands
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_VERSION = 2'd0;
	localparam logic [1:0] CFG_BIT_COUNT = 2'd1;
	localparam logic [1:0] CFG_HASH_COUNT = 2'd2;

	// Position schemes
	localparam logic [1:0] VER_INDEX = 2'd0;
	localparam logic [1:0] VER_TABLE = 2'd1;
	localparam logic [1:0] VER_SLICE = 2'd2;

	// Datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LATCH = 4'd1;
	localparam logic [3:0] OP_LOADH = 4'd2;
	localparam logic [3:0] OP_MUL0 = 4'd3;
	localparam logic [3:0] OP_MUL1 = 4'd4;
	localparam logic [3:0] OP_MUL2 = 4'd5;
	localparam logic [3:0] OP_XSH = 4'd6;
	localparam logic [3:0] OP_HXK = 4'd7;
	localparam logic [3:0] OP_MOD = 4'd8;
	localparam logic [3:0] OP_POS_ZERO = 4'd9;
	localparam logic [3:0] OP_TAKE = 4'd10;
	localparam logic [3:0] OP_SLICE = 4'd11;
	localparam logic [3:0] OP_RD = 4'd12;
	localparam logic [3:0] OP_CHK = 4'd13;
	localparam logic [3:0] OP_CLR = 4'd14;
	localparam logic [3:0] OP_OUT = 4'd15;

	typedef struct packed {
		logic [3:0] op;
		logic       tgt_k;
		logic       err;
	} bfaq_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] ver;
		logic       cfg_ok;
		logic       need_zero;
		logic       need_le_have;
		logic       len_full;
		logic       len_zero;
		logic       i_last;
		logic       bit_set;
		logic       mod_last;
		logic       clr_last;
		logic       out_free;
	} bfaq_sts_t;

	// Seed table for the table and slicing schemes
	function automatic logic [63:0] seed_tab(input logic [3:0] idx);
		logic [63:0] s;
		case (idx)
			4'd0: s = 64'h4b7db4c869874dd1;
			4'd1: s = 64'h43e9b39115fd33ba;
			4'd2: s = 64'h180be656098797e4;
			4'd3: s = 64'he21f17e9d2d0bae7;
			4'd4: s = 64'heaa42039facc7152;
			4'd5: s = 64'h0d3666daa04ff2fd;
			4'd6: s = 64'hcafb2c5b513bc4f0;
			4'd7: s = 64'hdbb86c8c0293d7be;
			4'd8: s = 64'hec978c08a6a50237;
			4'd9: s = 64'ha3601812c4207d5d;
			4'd10: s = 64'h6ad826554038feae;
			4'd11: s = 64'hebe6d4db55c4f77a;
			4'd12: s = 64'he976cceb2abbc306;
			4'd13: s = 64'heac2796bf5c2907b;
			4'd14: s = 64'h0673b5ce5e1e40fd;
			default: s = 64'h004e6cc070604495;
		endcase
		return s;
	endfunction

	// len * MUR_M for a key length of 0 to 8
	function automatic logic [63:0] len_mul(input logic [3:0] len);
		logic [63:0] r;
		case (len)
			4'd1: r = MUR_M;
			4'd2: r = 64'd2 * MUR_M;
			4'd3: r = 64'd3 * MUR_M;
			4'd4: r = 64'd4 * MUR_M;
			4'd5: r = 64'd5 * MUR_M;
			4'd6: r = 64'd6 * MUR_M;
			4'd7: r = 64'd7 * MUR_M;
			4'd8: r = 64'd8 * MUR_M;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/bfaq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfaq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfaq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384,
	parameter int ADDR_W = 14
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

>>> src/bfaq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfaq_datapath
// Config registers, Murmur hash unit, modulo unit, slicer and bit store.
// ----------------------------------------------------------------------------
module bfaq_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bfaq_pkg::bfaq_ctl_t ctl,
	output bfaq_pkg::bfaq_sts_t      sts,
	input  wire logic                cfg_valid,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [20:0]         cfg_data,
	input  wire logic [1:0]          cmd,
	input  wire logic [63:0]         key,
	input  wire logic [3:0]          key_len,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     present,
	output logic                     status
);

	localparam int L = bfaq_pkg::STORE_BITS_LOG2;
	localparam int AW = bfaq_pkg::ADDR_W;
	localparam int CW = bfaq_pkg::CNT_W;

	logic [1:0]  ver_q;
	logic [20:0] bc_q;
	logic [6:0]  hc_q;

	logic [1:0]    cmd_q;
	logic [63:0]   key_q;
	logic [3:0]    len_q;
	logic [63:0]   h_q, k_q, p_q, bits_q;
	logic [6:0]    have_q;
	logic [4:0]    hidx_q;
	logic [5:0]    i_q;
	logic          all_q;
	logic [L-1:0]  pos_q;
	logic [5:0]    mcnt_q;
	logic [AW-1:0] clr_q;
	logic          out_valid_q, present_q, status_q;

	logic [31:0]   bc_w;
	logic [CW-1:0] count;
	logic          pow2;
	logic [4:0]    need;
	logic [5:0]    nh_m1;
	logic [3:0]    len_c;
	logic [63:0]   kmask;
	logic [6:0]    idx;
	logic [63:0]   seed;
	logic [63:0]   x;
	logic [63:0]   pp;
	logic [CW-1:0] mod_t;
	logic [L-1:0]  smask;
	logic [6:0]    more;
	logic          clearing, ram_we, ram_en;
	logic [AW-1:0] ram_addr;
	logic [63:0]   ram_wdata, ram_rdata;

	// Effective bit count, power-of-two check and slice width
	always_comb begin
		bc_w = 32'(bc_q);
		if (bc_w == 32'd0) bc_w = 32'd1;
		if (bc_w > (32'd1 << L)) bc_w = 32'd1 << L;
		count = CW'(bc_w);
		pow2 = (count & (count - 1'b1)) == '0;
		need = '0;
		for (int b = 0; b < CW; b++) begin
			if (count[b]) need = 5'(b);
		end
	end

	// Effective hash count minus one
	always_comb begin
		if (hc_q == 7'd0) nh_m1 = 6'd0;
		else if (hc_q > 7'd64) nh_m1 = 6'd63;
		else nh_m1 = 6'(hc_q - 7'd1);
	end

	// Key length clamp and byte mask
	always_comb begin
		len_c = (key_len > 4'(bfaq_pkg::KEY_BYTES)) ? 4'(bfaq_pkg::KEY_BYTES) : key_len;
		for (int b = 0; b < 8; b++) begin
			kmask[8*b +: 8] = (4'(b) < len_c) ? 8'hff : 8'h00;
		end
	end

	// Seed for the current hash
	always_comb begin
		idx = (ver_q == bfaq_pkg::VER_SLICE) ? 7'(hidx_q) : 7'(i_q);
		if (ver_q == bfaq_pkg::VER_INDEX) seed = 64'(idx);
		else seed = bfaq_pkg::seed_tab(idx[3:0]) + 64'(idx);
	end

	// Multiply operand and one 32x32 partial product
	always_comb begin
		x = ctl.tgt_k ? k_q : h_q;
		case (ctl.op)
			bfaq_pkg::OP_MUL0: pp = x[31:0] * bfaq_pkg::MUR_M[31:0];
			bfaq_pkg::OP_MUL1: pp = x[31:0] * bfaq_pkg::MUR_M[63:32];
			default: pp = x[63:32] * bfaq_pkg::MUR_M[31:0];
		endcase
	end

	// Remainder step, slice mask
	always_comb begin
		mod_t = {pos_q, h_q[63]};
		if (mod_t >= count) mod_t = mod_t - count;
		smask = L'((64'd1 << need) - 64'd1);
		more = 7'(need) - have_q;
	end

	// Bit store port
	always_comb begin
		clearing = ctl.op == bfaq_pkg::OP_CLR;
		ram_we = clearing || (ctl.op == bfaq_pkg::OP_CHK && cmd_q == bfaq_pkg::CMD_ADD);
		ram_en = ram_we || ctl.op == bfaq_pkg::OP_RD;
		ram_addr = clearing ? clr_q : AW'(pos_q >> 6);
		ram_wdata = clearing ? 64'd0 : (ram_rdata | (64'd1 << pos_q[5:0]));
	end

	bfaq_ram #(
		.WIDTH(64),
		.DEPTH(bfaq_pkg::STORE_WORDS),
		.ADDR_W(AW)
	) u_store (
		.clk(clk),
		.en(ram_en),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= bfaq_pkg::VER_SLICE;
			bc_q <= 21'd1048576;
			hc_q <= 7'd4;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bfaq_pkg::CFG_VERSION: ver_q <= cfg_data[1:0];
					bfaq_pkg::CFG_BIT_COUNT: bc_q <= cfg_data;
					bfaq_pkg::CFG_HASH_COUNT: hc_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (ctl.op == bfaq_pkg::OP_LATCH) clr_q <= '0;
			if (clearing) begin
				if (clr_q == AW'(bfaq_pkg::STORE_WORDS - 1)) clr_q <= '0;
				else clr_q <= clr_q + 1'b1;
			end
			if (ctl.op == bfaq_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			bfaq_pkg::OP_LATCH: begin
				cmd_q <= cmd;
				key_q <= key & kmask;
				len_q <= len_c;
				i_q <= '0;
				hidx_q <= '0;
				have_q <= '0;
				bits_q <= '0;
				all_q <= 1'b1;
			end
			bfaq_pkg::OP_LOADH: begin
				h_q <= seed ^ bfaq_pkg::len_mul(len_q);
				k_q <= key_q;
				pos_q <= '0;
				mcnt_q <= '0;
			end
			bfaq_pkg::OP_MUL0: p_q <= pp;
			bfaq_pkg::OP_MUL1: p_q <= p_q + {pp[31:0], 32'd0};
			bfaq_pkg::OP_MUL2: begin
				if (ctl.tgt_k) k_q <= p_q + {pp[31:0], 32'd0};
				else h_q <= p_q + {pp[31:0], 32'd0};
			end
			bfaq_pkg::OP_XSH: begin
				if (ctl.tgt_k) k_q <= k_q ^ (k_q >> bfaq_pkg::MUR_R);
				else h_q <= h_q ^ (h_q >> bfaq_pkg::MUR_R);
			end
			bfaq_pkg::OP_HXK: h_q <= h_q ^ k_q;
			bfaq_pkg::OP_MOD: begin
				pos_q <= L'(mod_t);
				h_q <= h_q << 1;
				mcnt_q <= mcnt_q + 1'b1;
			end
			bfaq_pkg::OP_POS_ZERO: pos_q <= '0;
			bfaq_pkg::OP_TAKE: begin
				pos_q <= bits_q[L-1:0] & smask;
				bits_q <= bits_q >> need;
				have_q <= have_q - 7'(need);
			end
			bfaq_pkg::OP_SLICE: begin
				pos_q <= (bits_q[L-1:0] | L'(h_q << have_q[5:0])) & smask;
				bits_q <= h_q >> more;
				have_q <= 7'd64 - more;
				hidx_q <= hidx_q + 1'b1;
			end
			bfaq_pkg::OP_CHK: begin
				if (cmd_q == bfaq_pkg::CMD_QUERY && !ram_rdata[pos_q[5:0]]) all_q <= 1'b0;
				i_q <= i_q + 1'b1;
			end
			bfaq_pkg::OP_OUT: begin
				present_q <= cmd_q == bfaq_pkg::CMD_QUERY && all_q && !ctl.err;
				status_q <= ctl.err;
			end
			default: ;
		endcase
	end

	// Status toward the controller
	always_comb begin
		sts.cmd = cmd_q;
		sts.ver = ver_q;
		sts.cfg_ok = ver_q != 2'd3 && !(ver_q == bfaq_pkg::VER_SLICE && !pow2);
		sts.need_zero = need == 5'd0;
		sts.need_le_have = 7'(need) <= have_q;
		sts.len_full = len_q == 4'd8;
		sts.len_zero = len_q == 4'd0;
		sts.i_last = i_q == nh_m1;
		sts.bit_set = ram_rdata[pos_q[5:0]];
		sts.mod_last = mcnt_q == 6'd63;
		sts.clr_last = clr_q == AW'(bfaq_pkg::STORE_WORDS - 1);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign present = present_q;
	assign status = status_q;

endmodule
`default_nettype wire

>>> src/bfaq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfaq_ctrl
// Sequencer: dispatch, hash program, position loop, clear sweeps, result.
// ----------------------------------------------------------------------------
module bfaq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bfaq_pkg::bfaq_sts_t sts,
	output bfaq_pkg::bfaq_ctl_t      ctl
);

	localparam logic [3:0] S_RCLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_CLR = 4'd3;
	localparam logic [3:0] S_POS = 4'd4;
	localparam logic [3:0] S_HASH = 4'd5;
	localparam logic [3:0] S_MOD = 4'd6;
	localparam logic [3:0] S_SLICE = 4'd7;
	localparam logic [3:0] S_RD = 4'd8;
	localparam logic [3:0] S_CHK = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	localparam logic [4:0] STEP_LAST = 5'd16;

	logic [3:0] state_q, state_d;
	logic [4:0] step_q, step_d;
	logic       err_q, err_d;
	logic [3:0] hop;
	logic       htgt;

	// Hash program: Murmur64A as a list of single-unit steps
	always_comb begin
		htgt = 1'b0;
		case (step_q)
			5'd0: hop = bfaq_pkg::OP_LOADH;
			5'd1, 5'd5: begin hop = bfaq_pkg::OP_MUL0; htgt = 1'b1; end
			5'd2, 5'd6: begin hop = bfaq_pkg::OP_MUL1; htgt = 1'b1; end
			5'd3, 5'd7: begin hop = bfaq_pkg::OP_MUL2; htgt = 1'b1; end
			5'd4: begin hop = bfaq_pkg::OP_XSH; htgt = 1'b1; end
			5'd8: hop = bfaq_pkg::OP_HXK;
			5'd9, 5'd13: hop = bfaq_pkg::OP_MUL0;
			5'd10, 5'd14: hop = bfaq_pkg::OP_MUL1;
			5'd11, 5'd15: hop = bfaq_pkg::OP_MUL2;
			default: hop = bfaq_pkg::OP_XSH;
		endcase
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		err_d = err_q;
		ctl.op = bfaq_pkg::OP_NONE;
		ctl.tgt_k = 1'b0;
		ctl.err = err_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_RCLR: begin
				ctl.op = bfaq_pkg::OP_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op = bfaq_pkg::OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				err_d = 1'b0;
				if (sts.cmd == bfaq_pkg::CMD_CLEAR) begin
					state_d = S_CLR;
				end else if (sts.cmd != bfaq_pkg::CMD_ADD && sts.cmd != bfaq_pkg::CMD_QUERY) begin
					state_d = S_DONE;
				end else if (!sts.cfg_ok) begin
					err_d = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_POS;
				end
			end
			S_CLR: begin
				ctl.op = bfaq_pkg::OP_CLR;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_POS: begin
				step_d = '0;
				if (sts.ver == bfaq_pkg::VER_SLICE && sts.need_zero) begin
					ctl.op = bfaq_pkg::OP_POS_ZERO;
					state_d = S_RD;
				end else if (sts.ver == bfaq_pkg::VER_SLICE && sts.need_le_have) begin
					ctl.op = bfaq_pkg::OP_TAKE;
					state_d = S_RD;
				end else begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				ctl.op = hop;
				ctl.tgt_k = htgt;
				if (step_q == 5'd0) begin
					if (sts.len_full) step_d = 5'd1;
					else if (sts.len_zero) step_d = 5'd12;
					else step_d = 5'd8;
				end else begin
					step_d = step_q + 1'b1;
				end
				if (step_q == STEP_LAST) begin
					state_d = (sts.ver == bfaq_pkg::VER_SLICE) ? S_SLICE : S_MOD;
				end
			end
			S_MOD: begin
				ctl.op = bfaq_pkg::OP_MOD;
				if (sts.mod_last) state_d = S_RD;
			end
			S_SLICE: begin
				ctl.op = bfaq_pkg::OP_SLICE;
				state_d = S_RD;
			end
			S_RD: begin
				ctl.op = bfaq_pkg::OP_RD;
				state_d = S_CHK;
			end
			S_CHK: begin
				ctl.op = bfaq_pkg::OP_CHK;
				if (sts.i_last || (sts.cmd == bfaq_pkg::CMD_QUERY && !sts.bit_set)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_POS;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.op = bfaq_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RCLR;
			step_q <= '0;
			err_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			err_q <= err_d;
		end
	end

endmodule
`default_nettype wire

>>> src/bloom_filter_add_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_add_query
// Bloom filter add/query/clear over a 2^20-bit store, Murmur64A positions.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in   in_valid/in_ready      cmd, key, key_len
// out      out  out_valid/out_ready    present, status
//
// Versions 0/1, per position: a 6/10/17-step hash (by key length) on one
// 32x32 multiplier, a bit-serial remainder, then read and check. Version 2
// takes positions from a buffered hash and hashes anew when the buffer runs short.
// Each item also passes take, dispatch and result; clear and the pass after
// reset sweep all 16384 store words one word a cycle. A result may wait while the
// next item is taken; a full result slot stalls the sequencer. cfg always ready.
module bloom_filter_add_query (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [20:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] key,
	input  wire logic [3:0]  key_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             present,
	output logic             status
);

	bfaq_pkg::bfaq_ctl_t ctl;
	bfaq_pkg::bfaq_sts_t sts;

	assign cfg_ready = 1'b1;

	bfaq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.ctl(ctl)
	);

	bfaq_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.key(key),
		.key_len(key_len),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.present(present),
		.status(status)
	);

endmodule
`default_nettype wire
